// ===== src/smc_pkg.sv =====
// Package for the stack machine core: opcodes, result kinds, error codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package smc_pkg;

   localparam int STACK_DEPTH_DEF      = 255;
   localparam int DATA_WORDS_DEF       = 2048;
   localparam int PROGRAM_WORDS_DEF    = 4096;
   localparam int MAX_STRING_CHARS_DEF = 63;

   localparam int WORD_W   = 32;
   localparam int PC_W     = 12;
   localparam int COUNT_W  = 8;
   localparam int KIND_W   = 3;
   localparam int ERR_W    = 3;
   localparam int MODE_W   = 8;

   localparam logic [MODE_W-1:0] OP_PUSH     = 8'd0;
   localparam logic [MODE_W-1:0] OP_ADD      = 8'd1;
   localparam logic [MODE_W-1:0] OP_SUB      = 8'd2;
   localparam logic [MODE_W-1:0] OP_MUL      = 8'd3;
   localparam logic [MODE_W-1:0] OP_DUP      = 8'd4;
   localparam logic [MODE_W-1:0] OP_SWAP     = 8'd5;
   localparam logic [MODE_W-1:0] OP_POP      = 8'd6;
   localparam logic [MODE_W-1:0] OP_MOD      = 8'd7;
   localparam logic [MODE_W-1:0] OP_EQ       = 8'd8;
   localparam logic [MODE_W-1:0] OP_GE       = 8'd9;
   localparam logic [MODE_W-1:0] OP_LE       = 8'd10;
   localparam logic [MODE_W-1:0] OP_NE       = 8'd11;
   localparam logic [MODE_W-1:0] OP_JMP      = 8'd12;
   localparam logic [MODE_W-1:0] OP_JZ       = 8'd13;
   localparam logic [MODE_W-1:0] OP_SHOW     = 8'd14;
   localparam logic [MODE_W-1:0] OP_SAVE     = 8'd15;
   localparam logic [MODE_W-1:0] OP_LOAD     = 8'd16;
   localparam logic [MODE_W-1:0] OP_LT       = 8'd17;
   localparam logic [MODE_W-1:0] OP_GT       = 8'd18;
   localparam logic [MODE_W-1:0] OP_CONSOLE  = 8'd19;
   localparam logic [MODE_W-1:0] OP_SHOW_STR = 8'd20;
   localparam logic [MODE_W-1:0] OP_HALT     = 8'd21;

   localparam logic [KIND_W-1:0] KIND_STEP     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NUMBER   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CHAR     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_END      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_HALTED   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_HALT_ERR = 3'd5;

   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd2;
   localparam logic [ERR_W-1:0] ERR_ADDRESS   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_MOD_ZERO  = 3'd4;
   localparam logic [ERR_W-1:0] ERR_JUMP      = 3'd5;
   localparam logic [ERR_W-1:0] ERR_EMPTY     = 3'd6;
   localparam logic [ERR_W-1:0] ERR_TRUNC     = 3'd7;

   typedef enum logic [3:0] {
      ST_CLEAR,     // sweeping data memory to zero after reset
      ST_IDLE,      // waiting for an instruction
      ST_READ,      // operand reads issued, waiting for data
      ST_EXEC,      // check and execute
      ST_MOD,       // iterative remainder running
      ST_STR_READ,  // string character read issued
      ST_STR_CHECK, // string character data available
      ST_RESP,      // one result waiting in the output register
      ST_STR_RESP   // one character waiting in the output register
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the incoming instruction
      logic read_ops;    // read top two stack entries and memory at immediate
      logic exec;        // perform checks and commit the instruction
      logic mod_start;   // start the remainder unit
      logic mod_commit;  // write the remainder back
      logic str_read;    // read data memory at the string pointer
      logic str_emit;    // load a character result, advance pointer
      logic str_end;     // load the end-of-string result
      logic clear_step;  // write zero at the clear pointer
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_mod;       // instruction will use the remainder unit
      logic is_prints;    // instruction starts a string print
      logic mod_done;     // remainder ready
      logic str_more;     // pointer in range and word nonzero
      logic str_capped;   // character cap reached
      logic clear_last;   // clear pointer at last word
   } status_type;

endpackage

// ===== src/stack_machine_core.sv =====
// Top level of the stack machine core: stream ports, controller and datapath.
// Depends on smc_pkg, smc_controller and smc_datapath.
//
// One instruction is accepted per req_ transfer and answered by one or more
// rsp_ transfers; the last of them carries rsp_tlast. After reset the core
// sweeps its data memory to zero, one word a cycle (DATA_WORDS words, 2048
// by default), and holds req_tready low meanwhile. A plain instruction then
// passes through the accepting cycle, operand read, execute, and the result
// state, in which rsp_tvalid is high until the transfer takes place.
// Modulo runs a bit-serial remainder of 32 shift steps and one write-back
// before its result. String print takes a memory read, a check and a
// transfer for each character, and the same steps for the end mark.
// The next instruction is accepted in the cycle after the last result goes.
// The operand stack leaves entries that were never written undefined.
module stack_machine_core #(
   parameter int STACK_DEPTH      = smc_pkg::STACK_DEPTH_DEF,
   parameter int DATA_WORDS       = smc_pkg::DATA_WORDS_DEF,
   parameter int PROGRAM_WORDS    = smc_pkg::PROGRAM_WORDS_DEF,
   parameter int MAX_STRING_CHARS = smc_pkg::MAX_STRING_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: mode[7:0], immediate[39:8], console_value[71:40], console_valid[72]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: out_value[31:0], next_pc[43:32], error_code[46:44],
   // stack_count[54:47]
   output logic [55:0] rsp_tdata,
   // tuser: out_kind[2:0]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   smc_pkg::cmd_type    cmd;
   smc_pkg::status_type status;
   logic [smc_pkg::KIND_W-1:0]  kind;
   logic [smc_pkg::WORD_W-1:0]  value;
   logic [smc_pkg::PC_W-1:0]    npc;
   logic [smc_pkg::ERR_W-1:0]   err;
   logic [smc_pkg::COUNT_W-1:0] count;

   smc_controller u_ctrl (
      .clock, .reset,
      .req_fire (req_tvalid && req_tready),
      .rsp_fire (rsp_tvalid && rsp_tready),
      .status, .cmd,
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid)
   );

   smc_datapath #(
      .STACK_DEPTH(STACK_DEPTH), .DATA_WORDS(DATA_WORDS),
      .PROGRAM_WORDS(PROGRAM_WORDS), .MAX_STRING_CHARS(MAX_STRING_CHARS)
   ) u_dp (
      .clock, .reset, .cmd, .status,
      .in_mode          (req_tdata[7:0]),
      .in_immediate     (req_tdata[39:8]),
      .in_console_value (req_tdata[71:40]),
      .in_console_valid (req_tdata[72]),
      .res_kind (kind), .res_value (value), .res_next_pc (npc),
      .res_error (err), .res_count (count), .res_last (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, count, err, npc, value};
   assign rsp_tuser = kind;

endmodule

// ===== src/smc_datapath.sv =====
// Datapath of the stack machine core: operand stack and data memories,
// ALU, remainder unit, program counter, halt flags and result register.
// Depends on smc_pkg.
module smc_datapath #(
   parameter int STACK_DEPTH      = smc_pkg::STACK_DEPTH_DEF,
   parameter int DATA_WORDS       = smc_pkg::DATA_WORDS_DEF,
   parameter int PROGRAM_WORDS    = smc_pkg::PROGRAM_WORDS_DEF,
   parameter int MAX_STRING_CHARS = smc_pkg::MAX_STRING_CHARS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  smc_pkg::cmd_type             cmd,
   output smc_pkg::status_type          status,
   input  logic [smc_pkg::MODE_W-1:0]   in_mode,
   input  logic [smc_pkg::WORD_W-1:0]   in_immediate,
   input  logic [smc_pkg::WORD_W-1:0]   in_console_value,
   input  logic                         in_console_valid,
   output logic [smc_pkg::KIND_W-1:0]   res_kind,
   output logic [smc_pkg::WORD_W-1:0]   res_value,
   output logic [smc_pkg::PC_W-1:0]     res_next_pc,
   output logic [smc_pkg::ERR_W-1:0]    res_error,
   output logic [smc_pkg::COUNT_W-1:0]  res_count,
   output logic                         res_last
);

   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int DA_W  = $clog2(DATA_WORDS);
   localparam int PA_W  = $clog2(PROGRAM_WORDS);
   localparam int CH_W  = 6;
   localparam int W     = smc_pkg::WORD_W;

   // Instruction registers.
   logic [smc_pkg::MODE_W-1:0] op_ff, op_in;
   logic [W-1:0]               imm_ff, imm_in;
   logic [W-1:0]               cval_ff, cval_in;
   logic                       cvalid_ff, cvalid_in;

   // Architectural state.
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [PA_W-1:0] pc_ff, pc_in;
   logic            halted_ff, halted_in;
   logic            herr_ff, herr_in;

   // Memories.
   logic [W-1:0] stack_mem [STACK_DEPTH];
   logic [W-1:0] data_mem  [DATA_WORDS];
   logic [W-1:0] top_ff, second_ff, dread_ff;

   // String and clear state.
   logic [DA_W:0]    sptr_ff, sptr_in;
   logic [CH_W-1:0]  nchar_ff, nchar_in;
   logic [DA_W-1:0]  clr_ff, clr_in;

   // Remainder unit.
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     div_ff, div_in;
   logic [5:0]       mcnt_ff, mcnt_in;
   logic             mneg_ff, mneg_in;
   logic             mbusy_ff, mbusy_in;

   // Result register.
   logic [smc_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [W-1:0]               val_ff, val_in;
   logic [PA_W-1:0]            npc_ff, npc_in;
   logic [smc_pkg::ERR_W-1:0]  err_ff, err_in;
   logic                       last_ff, last_in;

   // Stack write port.
   logic             swe;
   logic [SA_W-1:0]  swa;
   logic [W-1:0]     swd;
   // Data memory write port.
   logic             dwe;
   logic [DA_W-1:0]  dwa;
   logic [W-1:0]     dwd;
   logic [DA_W-1:0]  dra;

   // Swap needs a second write; done with a pending register.
   logic             swp_ff, swp_in;
   logic [W-1:0]     swpd_ff, swpd_in;

   // Decoded and derived values.
   logic [SP_W-1:0]  need;
   logic             grows;
   logic             is_bin;
   logic [smc_pkg::ERR_W-1:0] chk;
   logic             imm_data_ok, imm_pc_ok, top_addr_ok;
   logic [PA_W-1:0]  pc1, pc2;
   logic [W-1:0]     alu;
   logic [W-1:0]     sa, sb;
   logic [W:0]       rem_try;
   logic             str_more;

   assign sa = top_ff ^ {1'b1, {(W-1){1'b0}}};
   assign sb = second_ff ^ {1'b1, {(W-1){1'b0}}};

   assign pc1 = pc_ff + PA_W'(1);
   assign pc2 = pc_ff + PA_W'(2);

   assign imm_data_ok = !imm_ff[W-1] && (imm_ff < W'(DATA_WORDS));
   assign imm_pc_ok   = !imm_ff[W-1] && (imm_ff < W'(PROGRAM_WORDS));
   assign top_addr_ok = !top_ff[W-1] && (top_ff < W'(DATA_WORDS));

   always_comb begin
      need  = '0;
      grows = 1'b0;
      unique case (op_ff)
         smc_pkg::OP_PUSH, smc_pkg::OP_LOAD: grows = 1'b1;
         smc_pkg::OP_DUP: begin
            need  = SP_W'(1);
            grows = 1'b1;
         end
         smc_pkg::OP_CONSOLE: grows = cvalid_ff;
         smc_pkg::OP_ADD, smc_pkg::OP_SUB, smc_pkg::OP_MUL, smc_pkg::OP_SWAP,
         smc_pkg::OP_MOD, smc_pkg::OP_EQ, smc_pkg::OP_GE, smc_pkg::OP_LE,
         smc_pkg::OP_NE, smc_pkg::OP_LT, smc_pkg::OP_GT: need = SP_W'(2);
         smc_pkg::OP_POP, smc_pkg::OP_JZ, smc_pkg::OP_SAVE,
         smc_pkg::OP_SHOW_STR: need = SP_W'(1);
         default: ;
      endcase
   end

   always_comb begin
      case (op_ff)
         smc_pkg::OP_ADD, smc_pkg::OP_SUB, smc_pkg::OP_MUL, smc_pkg::OP_MOD,
         smc_pkg::OP_EQ, smc_pkg::OP_GE, smc_pkg::OP_LE, smc_pkg::OP_NE,
         smc_pkg::OP_LT, smc_pkg::OP_GT: is_bin = 1'b1;
         default: is_bin = 1'b0;
      endcase
   end

   // Error priority follows the checks in order.
   always_comb begin
      chk = smc_pkg::ERR_NONE;
      if (sp_ff < need)
         chk = smc_pkg::ERR_UNDERFLOW;
      else if (grows && sp_ff >= SP_W'(STACK_DEPTH))
         chk = smc_pkg::ERR_OVERFLOW;
      else if ((op_ff == smc_pkg::OP_SAVE || op_ff == smc_pkg::OP_LOAD) && !imm_data_ok)
         chk = smc_pkg::ERR_ADDRESS;
      else if (op_ff == smc_pkg::OP_MOD && top_ff == '0)
         chk = smc_pkg::ERR_MOD_ZERO;
      else if ((op_ff == smc_pkg::OP_JMP || (op_ff == smc_pkg::OP_JZ && top_ff == '0))
               && !imm_pc_ok)
         chk = smc_pkg::ERR_JUMP;
      else if (op_ff == smc_pkg::OP_SHOW_STR && !top_addr_ok)
         chk = smc_pkg::ERR_ADDRESS;
   end

   // ALU: a is second (deeper), b is top.
   always_comb begin
      case (op_ff)
         smc_pkg::OP_ADD: alu = second_ff + top_ff;
         smc_pkg::OP_SUB: alu = second_ff - top_ff;
         smc_pkg::OP_MUL: alu = second_ff * top_ff;
         smc_pkg::OP_EQ:  alu = W'(second_ff == top_ff);
         smc_pkg::OP_NE:  alu = W'(second_ff != top_ff);
         smc_pkg::OP_GE:  alu = W'(sb >= sa);
         smc_pkg::OP_LE:  alu = W'(sb <= sa);
         smc_pkg::OP_LT:  alu = W'(sb < sa);
         default:         alu = W'(sb > sa);
      endcase
   end

   assign rem_try = {rem_ff, quo_ff[W-1]} - {1'b0, div_ff};

   assign str_more = !sptr_ff[DA_W] && (sptr_ff < (DA_W+1)'(DATA_WORDS))
                     && (dread_ff != '0);

   assign status.is_mod     = (op_ff == smc_pkg::OP_MOD) && (chk == smc_pkg::ERR_NONE)
                              && !halted_ff;
   assign status.is_prints  = (op_ff == smc_pkg::OP_SHOW_STR)
                              && (chk == smc_pkg::ERR_NONE) && !halted_ff;
   assign status.mod_done   = mbusy_ff && (mcnt_ff == '0);
   assign status.str_more   = str_more;
   assign status.str_capped = (nchar_ff == CH_W'(MAX_STRING_CHARS));
   assign status.clear_last = (clr_ff == DA_W'(DATA_WORDS - 1));

   always_comb begin
      op_in = op_ff; imm_in = imm_ff; cval_in = cval_ff; cvalid_in = cvalid_ff;
      sp_in = sp_ff; pc_in = pc_ff; halted_in = halted_ff; herr_in = herr_ff;
      sptr_in = sptr_ff; nchar_in = nchar_ff; clr_in = clr_ff;
      rem_in = rem_ff; quo_in = quo_ff; div_in = div_ff; mcnt_in = mcnt_ff;
      mneg_in = mneg_ff; mbusy_in = mbusy_ff;
      kind_in = kind_ff; val_in = val_ff; npc_in = npc_ff; err_in = err_ff;
      last_in = last_ff;
      swe = 1'b0; swa = '0; swd = '0;
      dwe = 1'b0; dwa = '0; dwd = '0;
      dra = imm_ff[DA_W-1:0];
      swp_in = 1'b0; swpd_in = swpd_ff;

      if (swp_ff) begin
         swe = 1'b1;
         swa = SA_W'(sp_ff - SP_W'(2));
         swd = swpd_ff;
      end

      if (cmd.clear_step) begin
         dwe = 1'b1;
         dwa = clr_ff;
         clr_in = clr_ff + DA_W'(1);
      end

      if (cmd.capture) begin
         op_in = in_mode; imm_in = in_immediate;
         cval_in = in_console_value; cvalid_in = in_console_valid;
      end

      if (cmd.read_ops) dra = imm_ff[DA_W-1:0];
      if (cmd.str_read) dra = sptr_ff[DA_W-1:0];

      if (cmd.exec) begin
         kind_in = smc_pkg::KIND_STEP; val_in = '0; err_in = smc_pkg::ERR_NONE;
         last_in = 1'b1; npc_in = pc1;
         if (halted_ff) begin
            kind_in = herr_ff ? smc_pkg::KIND_HALT_ERR : smc_pkg::KIND_HALTED;
            npc_in  = pc_ff;
         end else if (chk != smc_pkg::ERR_NONE) begin
            halted_in = 1'b1; herr_in = 1'b1;
            kind_in = smc_pkg::KIND_HALT_ERR; err_in = chk; npc_in = pc_ff;
         end else begin
            unique case (op_ff)
               smc_pkg::OP_PUSH: begin
                  swe = 1'b1; swa = SA_W'(sp_ff); swd = imm_ff;
                  sp_in = sp_ff + SP_W'(1); npc_in = pc2;
               end
               smc_pkg::OP_DUP: begin
                  swe = 1'b1; swa = SA_W'(sp_ff); swd = top_ff;
                  sp_in = sp_ff + SP_W'(1);
               end
               smc_pkg::OP_SWAP: begin
                  swe = 1'b1; swa = SA_W'(sp_ff - SP_W'(1)); swd = second_ff;
                  swp_in = 1'b1; swpd_in = top_ff;
               end
               smc_pkg::OP_POP: sp_in = sp_ff - SP_W'(1);
               smc_pkg::OP_MOD: begin
                  sp_in = sp_ff;
               end
               smc_pkg::OP_JMP: npc_in = imm_ff[PA_W-1:0];
               smc_pkg::OP_JZ: begin
                  sp_in  = sp_ff - SP_W'(1);
                  npc_in = (top_ff == '0) ? imm_ff[PA_W-1:0] : pc2;
               end
               smc_pkg::OP_SHOW: begin
                  if (sp_ff == '0) err_in = smc_pkg::ERR_EMPTY;
                  else begin
                     kind_in = smc_pkg::KIND_NUMBER; val_in = top_ff;
                  end
               end
               smc_pkg::OP_SAVE: begin
                  dwe = 1'b1; dwa = imm_ff[DA_W-1:0]; dwd = top_ff;
                  sp_in = sp_ff - SP_W'(1); npc_in = pc2;
               end
               smc_pkg::OP_LOAD: begin
                  swe = 1'b1; swa = SA_W'(sp_ff); swd = dread_ff;
                  sp_in = sp_ff + SP_W'(1); npc_in = pc2;
               end
               smc_pkg::OP_CONSOLE: begin
                  if (cvalid_ff) begin
                     swe = 1'b1; swa = SA_W'(sp_ff); swd = cval_ff;
                     sp_in = sp_ff + SP_W'(1);
                  end
               end
               smc_pkg::OP_SHOW_STR: begin
                  sp_in = sp_ff - SP_W'(1);
                  sptr_in = top_ff[DA_W:0];
                  nchar_in = '0;
               end
               smc_pkg::OP_HALT: begin
                  halted_in = 1'b1;
                  kind_in = smc_pkg::KIND_HALTED; npc_in = pc_ff;
               end
               default: begin
                  if (is_bin) begin
                     swe = 1'b1; swa = SA_W'(sp_ff - SP_W'(2)); swd = alu;
                     sp_in = sp_ff - SP_W'(1);
                  end
               end
            endcase
            if (op_ff != smc_pkg::OP_HALT) pc_in = npc_in;
         end
      end

      if (cmd.mod_start) begin
         mneg_in  = second_ff[W-1];
         quo_in   = second_ff[W-1] ? (W'(0) - second_ff) : second_ff;
         div_in   = top_ff[W-1] ? (W'(0) - top_ff) : top_ff;
         rem_in   = '0;
         mcnt_in  = 6'd32;
         mbusy_in = 1'b1;
      end else if (mbusy_ff && mcnt_ff != '0) begin
         if (!rem_try[W]) rem_in = rem_try[W-1:0];
         else rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
         quo_in  = {quo_ff[W-2:0], 1'b0};
         mcnt_in = mcnt_ff - 6'd1;
      end

      if (cmd.mod_commit) begin
         mbusy_in = 1'b0;
         swe = 1'b1; swa = SA_W'(sp_ff - SP_W'(2));
         swd = mneg_ff ? (W'(0) - rem_ff) : rem_ff;
         sp_in = sp_ff - SP_W'(1);
      end

      if (cmd.str_emit) begin
         kind_in = smc_pkg::KIND_CHAR; val_in = {{(W-8){1'b0}}, dread_ff[7:0]};
         err_in = smc_pkg::ERR_NONE; last_in = 1'b0;
         sptr_in = sptr_ff + (DA_W+1)'(1);
         nchar_in = nchar_ff + CH_W'(1);
      end
      if (cmd.str_end) begin
         kind_in = smc_pkg::KIND_END; val_in = '0; last_in = 1'b1;
         err_in = (str_more && status.str_capped) ? smc_pkg::ERR_TRUNC
                                                   : smc_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0; pc_ff <= '0; halted_ff <= 1'b0; herr_ff <= 1'b0;
         clr_ff <= '0; mbusy_ff <= 1'b0; mcnt_ff <= '0; swp_ff <= 1'b0;
      end else begin
         sp_ff <= sp_in; pc_ff <= pc_in; halted_ff <= halted_in; herr_ff <= herr_in;
         clr_ff <= clr_in; mbusy_ff <= mbusy_in; mcnt_ff <= mcnt_in; swp_ff <= swp_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; imm_ff <= imm_in; cval_ff <= cval_in; cvalid_ff <= cvalid_in;
      sptr_ff <= sptr_in; nchar_ff <= nchar_in;
      rem_ff <= rem_in; quo_ff <= quo_in; div_ff <= div_in; mneg_ff <= mneg_in;
      kind_ff <= kind_in; val_ff <= val_in; npc_ff <= npc_in; err_ff <= err_in;
      last_ff <= last_in; swpd_ff <= swpd_in;
   end

   // Operand stack: one write, two registered reads.
   always_ff @(posedge clock) begin
      if (swe) stack_mem[swa] <= swd;
      if (cmd.read_ops) begin
         top_ff    <= stack_mem[SA_W'(sp_ff - SP_W'(1))];
         second_ff <= stack_mem[SA_W'(sp_ff - SP_W'(2))];
      end
   end

   // Data memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (dwe) data_mem[dwa] <= dwd;
      if (cmd.read_ops || cmd.str_read) dread_ff <= data_mem[dra];
   end

   assign res_kind    = kind_ff;
   assign res_value   = val_ff;
   assign res_next_pc = smc_pkg::PC_W'(npc_ff);
   assign res_error   = err_ff;
   assign res_count   = smc_pkg::COUNT_W'(sp_ff);
   assign res_last    = last_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH)) else $error("stack pointer past depth");
   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff) else $error("halt flag dropped");
   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> $stable(pc_ff)) else $error("pc moved while halted");
   a_herr_implies: assert property (@(posedge clock) disable iff (reset)
      herr_ff |-> halted_ff) else $error("error flag without halt");

endmodule

// ===== src/smc_controller.sv =====
// Controller state machine of the stack machine core: sequences reads,
// execution, the remainder unit, string output and the memory clear.
// Depends on smc_pkg.
module smc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic                 rsp_fire,
   input  smc_pkg::status_type  status,
   output smc_pkg::cmd_type     cmd,
   output logic                 req_ready,
   output logic                 rsp_valid
);

   smc_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smc_pkg::ST_CLEAR: if (status.clear_last) state_in = smc_pkg::ST_IDLE;
         smc_pkg::ST_IDLE:  if (req_fire) state_in = smc_pkg::ST_READ;
         smc_pkg::ST_READ:  state_in = smc_pkg::ST_EXEC;
         smc_pkg::ST_EXEC: begin
            if (status.is_mod) state_in = smc_pkg::ST_MOD;
            else if (status.is_prints) state_in = smc_pkg::ST_STR_READ;
            else state_in = smc_pkg::ST_RESP;
         end
         smc_pkg::ST_MOD: if (status.mod_done) state_in = smc_pkg::ST_RESP;
         smc_pkg::ST_STR_READ: state_in = smc_pkg::ST_STR_CHECK;
         smc_pkg::ST_STR_CHECK: begin
            if (status.str_more && !status.str_capped) state_in = smc_pkg::ST_STR_RESP;
            else state_in = smc_pkg::ST_RESP;
         end
         smc_pkg::ST_STR_RESP: if (rsp_fire) state_in = smc_pkg::ST_STR_READ;
         smc_pkg::ST_RESP: if (rsp_fire) state_in = smc_pkg::ST_IDLE;
         default: state_in = smc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         smc_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         smc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_fire;
         end
         smc_pkg::ST_READ: cmd.read_ops = 1'b1;
         smc_pkg::ST_EXEC: begin
            if (status.is_mod) cmd.mod_start = 1'b1;
            else cmd.exec = 1'b1;
         end
         smc_pkg::ST_MOD: if (status.mod_done) begin
            cmd.exec = 1'b1;
            cmd.mod_commit = 1'b1;
         end
         smc_pkg::ST_STR_READ: cmd.str_read = 1'b1;
         smc_pkg::ST_STR_CHECK: begin
            if (status.str_more && !status.str_capped) cmd.str_emit = 1'b1;
            else cmd.str_end = 1'b1;
         end
         smc_pkg::ST_STR_RESP, smc_pkg::ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= smc_pkg::ST_CLEAR;
      else state_ff <= state_in;
   end

   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_exec_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smc_pkg::ST_READ) |=> (state_ff == smc_pkg::ST_EXEC))
      else $error("read not followed by execute");
   a_mod_one: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mod_start, cmd.str_emit, cmd.str_end, cmd.clear_step}))
      else $error("conflicting datapath commands");

endmodule

// ===== tb/sv/smc_checker.sv =====
// Checker for the stack machine core: watches both stream channels, predicts
// the results of each accepted instruction and compares them field by field.
// Depends on smc_pkg.
module smc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_count
);

   localparam int DEPTH = smc_pkg::STACK_DEPTH_DEF;
   localparam int WORDS = smc_pkg::DATA_WORDS_DEF;
   localparam int PROG  = smc_pkg::PROGRAM_WORDS_DEF;
   localparam int CAP   = smc_pkg::MAX_STRING_CHARS_DEF;

   typedef struct packed {
      logic [smc_pkg::KIND_W-1:0]  kind;
      logic [smc_pkg::WORD_W-1:0]  value;
      logic [smc_pkg::PC_W-1:0]    pc;
      logic [smc_pkg::ERR_W-1:0]   err;
      logic [smc_pkg::COUNT_W-1:0] count;
      logic                        last;
   } result_type;

   logic [31:0]  stack_mem [DEPTH];
   logic [31:0]  data_mem [WORDS];
   int           depth_now;
   logic [11:0]  pc_now;
   logic         stopped, stopped_err;
   result_type   expected_results [$];

   function automatic logic fits(logic [31:0] v, int size);
      return !v[31] && v < size;
   endfunction

   function automatic logic [31:0] alu(logic [7:0] op, logic [31:0] a, logic [31:0] b);
      logic signed [31:0] sa, sb;
      logic [31:0]        ua, ub, r;
      sa = a;
      sb = b;
      case (op)
         smc_pkg::OP_ADD: return a + b;
         smc_pkg::OP_SUB: return a - b;
         smc_pkg::OP_MUL: return a * b;
         smc_pkg::OP_MOD: begin
            // Remainder truncates toward zero and follows the dividend's sign.
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            r = ua % ub;
            return a[31] ? -r : r;
         end
         smc_pkg::OP_EQ:  return {31'd0, a == b};
         smc_pkg::OP_GE:  return {31'd0, sa >= sb};
         smc_pkg::OP_LE:  return {31'd0, sa <= sb};
         smc_pkg::OP_NE:  return {31'd0, a != b};
         smc_pkg::OP_LT:  return {31'd0, sa < sb};
         default: return {31'd0, sa > sb};
      endcase
   endfunction

   task automatic add_result(logic [2:0] kind, logic [31:0] value, logic [11:0] pc,
                             logic [2:0] err, logic last);
      result_type r;
      r.kind = kind;
      r.value = value;
      r.pc = pc;
      r.err = err;
      r.count = depth_now[7:0];
      r.last = last;
      expected_results.push_back(r);
   endtask

   task automatic execute(logic [79:0] item);
      logic [7:0]  op;
      logic [31:0] imm, cval, top, addr;
      logic        cvalid, grows;
      logic [11:0] pc, npc;
      logic [2:0]  err, trunc;
      int          need, k;
      op = item[7:0];
      imm = item[39:8];
      cval = item[71:40];
      cvalid = item[72];
      pc = pc_now;
      npc = pc + 12'd1;
      need = 0;
      err = smc_pkg::ERR_NONE;
      grows = 1'b0;
      top = depth_now > 0 ? stack_mem[depth_now-1] : '0;
      if (stopped) begin
         add_result(stopped_err ? smc_pkg::KIND_HALT_ERR : smc_pkg::KIND_HALTED, '0, pc,
                    smc_pkg::ERR_NONE, 1'b1);
         return;
      end
      case (op)
         smc_pkg::OP_PUSH, smc_pkg::OP_LOAD: grows = 1'b1;
         smc_pkg::OP_DUP: begin need = 1; grows = 1'b1; end
         smc_pkg::OP_CONSOLE: grows = cvalid;
         smc_pkg::OP_ADD, smc_pkg::OP_SUB, smc_pkg::OP_MUL, smc_pkg::OP_SWAP,
         smc_pkg::OP_MOD, smc_pkg::OP_EQ, smc_pkg::OP_GE, smc_pkg::OP_LE,
         smc_pkg::OP_NE, smc_pkg::OP_LT, smc_pkg::OP_GT: need = 2;
         smc_pkg::OP_POP, smc_pkg::OP_JZ, smc_pkg::OP_SAVE,
         smc_pkg::OP_SHOW_STR: need = 1;
         default: ;
      endcase
      if (depth_now < need) err = smc_pkg::ERR_UNDERFLOW;
      else if (grows && depth_now >= DEPTH) err = smc_pkg::ERR_OVERFLOW;
      else if ((op == smc_pkg::OP_SAVE || op == smc_pkg::OP_LOAD) && !fits(imm, WORDS))
         err = smc_pkg::ERR_ADDRESS;
      else if (op == smc_pkg::OP_MOD && top == 0) err = smc_pkg::ERR_MOD_ZERO;
      else if ((op == smc_pkg::OP_JMP || (op == smc_pkg::OP_JZ && top == 0))
               && !fits(imm, PROG))
         err = smc_pkg::ERR_JUMP;
      else if (op == smc_pkg::OP_SHOW_STR && !fits(top, WORDS))
         err = smc_pkg::ERR_ADDRESS;
      if (err != smc_pkg::ERR_NONE) begin
         stopped = 1'b1;
         stopped_err = 1'b1;
         add_result(smc_pkg::KIND_HALT_ERR, '0, pc, err, 1'b1);
         return;
      end
      case (op)
         smc_pkg::OP_PUSH: begin
            stack_mem[depth_now] = imm;
            depth_now++;
            npc = pc + 12'd2;
         end
         smc_pkg::OP_ADD, smc_pkg::OP_SUB, smc_pkg::OP_MUL, smc_pkg::OP_MOD,
         smc_pkg::OP_EQ, smc_pkg::OP_GE, smc_pkg::OP_LE, smc_pkg::OP_NE,
         smc_pkg::OP_LT, smc_pkg::OP_GT: begin
            stack_mem[depth_now-2] = alu(op, stack_mem[depth_now-2], top);
            depth_now--;
         end
         smc_pkg::OP_DUP: begin
            stack_mem[depth_now] = top;
            depth_now++;
         end
         smc_pkg::OP_SWAP: begin
            stack_mem[depth_now-1] = stack_mem[depth_now-2];
            stack_mem[depth_now-2] = top;
         end
         smc_pkg::OP_POP: depth_now--;
         smc_pkg::OP_JMP: npc = imm[11:0];
         smc_pkg::OP_JZ: begin
            depth_now--;
            npc = top == 0 ? imm[11:0] : pc + 12'd2;
         end
         smc_pkg::OP_SHOW: begin
            pc_now = npc;
            if (depth_now == 0)
               add_result(smc_pkg::KIND_STEP, '0, npc, smc_pkg::ERR_EMPTY, 1'b1);
            else add_result(smc_pkg::KIND_NUMBER, top, npc, smc_pkg::ERR_NONE, 1'b1);
            return;
         end
         smc_pkg::OP_SAVE: begin
            depth_now--;
            data_mem[imm] = top;
            npc = pc + 12'd2;
         end
         smc_pkg::OP_LOAD: begin
            stack_mem[depth_now] = data_mem[imm];
            depth_now++;
            npc = pc + 12'd2;
         end
         smc_pkg::OP_CONSOLE: if (cvalid) begin
            stack_mem[depth_now] = cval;
            depth_now++;
         end
         smc_pkg::OP_SHOW_STR: begin
            depth_now--;
            addr = top;
            pc_now = npc;
            k = 0;
            trunc = smc_pkg::ERR_NONE;
            // The string ends at a zero word or at the end of data memory.
            while (addr < WORDS && data_mem[addr] != 0) begin
               if (k >= CAP) begin
                  trunc = smc_pkg::ERR_TRUNC;
                  break;
               end
               add_result(smc_pkg::KIND_CHAR, {24'd0, data_mem[addr][7:0]}, npc,
                          smc_pkg::ERR_NONE, 1'b0);
               k++;
               addr++;
            end
            add_result(smc_pkg::KIND_END, '0, npc, trunc, 1'b1);
            return;
         end
         smc_pkg::OP_HALT: begin
            stopped = 1'b1;
            add_result(smc_pkg::KIND_HALTED, '0, pc, smc_pkg::ERR_NONE, 1'b1);
            return;
         end
         default: ;
      endcase
      pc_now = npc;
      add_result(smc_pkg::KIND_STEP, '0, npc, smc_pkg::ERR_NONE, 1'b1);
   endtask

   task automatic compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         fail_count = 0;
         depth_now = 0;
         pc_now = '0;
         stopped = 1'b0;
         stopped_err = 1'b0;
         expected_results.delete();
         foreach (data_mem[i]) data_mem[i] = '0;
         foreach (stack_mem[i]) stack_mem[i] = '0;
      end else begin
         if (req_tvalid && req_tready) execute(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transfer: %h %h", rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               compare("out_kind", 32'(want.kind), 32'(rsp_tuser));
               compare("out_value", want.value, rsp_tdata[31:0]);
               compare("next_pc", 32'(want.pc), 32'(rsp_tdata[43:32]));
               compare("error_code", 32'(want.err), 32'(rsp_tdata[46:44]));
               compare("stack_count", 32'(want.count), 32'(rsp_tdata[54:47]));
               compare("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the stack machine core: clock, reset, instruction
// stimulus, result back-pressure and the verdict.
// Depends on smc_pkg, smc_checker and stack_machine_core.
module tb_top;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;   // mode, immediate, console_value, console_valid
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // out_value, next_pc, error_code, stack_count
   logic [2:0]  rsp_tuser;   // out_kind
   logic        rsp_tlast;
   int          fail_count;
   int          pending_count;
   int          cycle_count;
   int          sent;
   logic        calm;        // no idling in the final stretch

   localparam int LIMIT = 3_000_000;

   stack_machine_core dut (.*);

   smc_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Cycle guard against a hung handshake.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   // Receiver side: random stall bursts, none once the run is calm.
   initial begin
      int n;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         n = $urandom_range(1, 15);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1;
         repeat (n) @(posedge clock);
      end
   end

   // One instruction transfer, followed by an occasional idle burst.
   task automatic send(logic [7:0] op, logic [31:0] imm,
                       logic [31:0] cval = '0, logic cvalid = 1'b1);
      req_tvalid <= 1;
      req_tdata <= {7'd0, cvalid, cval, imm, op};
      do @(posedge clock); while (!req_tready);
      sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Stores a string of random nonzero words starting at base.
   task automatic put_string(int base, int len);
      for (int i = 0; i < len; i++) begin
         send(smc_pkg::OP_PUSH, $urandom_range(1, 255) | ($urandom << 8));
         send(smc_pkg::OP_SAVE, 32'(base + i));
      end
   endtask

   initial begin
      int depth;
      logic [7:0] op;
      sent = 0;
      calm = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: extremes, a selection of opcodes, empty print, string cases.
      send(smc_pkg::OP_SHOW, 0);                   // empty print
      send(smc_pkg::OP_PUSH, 32'h8000_0000);
      send(smc_pkg::OP_PUSH, 32'h7fff_ffff);
      send(smc_pkg::OP_ADD, 0);
      send(smc_pkg::OP_PUSH, 32'hffff_fff9);
      send(smc_pkg::OP_PUSH, 3);
      send(smc_pkg::OP_MOD, 0);
      send(smc_pkg::OP_CONSOLE, 0, 32'hffff_ffff, 1'b1);
      send(smc_pkg::OP_CONSOLE, 0, 32'h1234_5678, 1'b0);  // no valid console value
      send(smc_pkg::OP_DUP, 0);
      send(smc_pkg::OP_SWAP, 0);
      send(smc_pkg::OP_MUL, 0);
      send(smc_pkg::OP_SHOW, 0);
      send(smc_pkg::OP_SAVE, 2047);
      send(smc_pkg::OP_LOAD, 2047);
      send(smc_pkg::OP_POP, 0);
      send(smc_pkg::OP_JMP, 4095);
      send(smc_pkg::OP_PUSH, 5);
      send(smc_pkg::OP_JZ, 32'hffff_ffff);         // not taken, target unchecked
      send(8'd255, 0);                             // undefined opcode
      // A string that runs past the cap.
      put_string(100, 65);
      send(smc_pkg::OP_PUSH, 100);
      send(smc_pkg::OP_SHOW_STR, 0);
      // A string that runs into the end of data memory.
      put_string(2046, 2);
      send(smc_pkg::OP_PUSH, 2046);
      send(smc_pkg::OP_SHOW_STR, 0);
      send(smc_pkg::OP_PUSH, 2040);
      send(smc_pkg::OP_SHOW_STR, 0);               // zero word: empty string

      // Random part: mostly well-formed, stack-aware instructions.
      depth = 0;
      while (sent < 260) begin
         if (sent > 230) calm = 1;
         op = 8'($urandom_range(0, 21));
         if ($urandom_range(0, 19) == 0) op = 8'($urandom_range(22, 255));
         case (op)
            smc_pkg::OP_PUSH, smc_pkg::OP_CONSOLE: begin
               send(op, $urandom, $urandom, 1'($urandom_range(0, 1)));
               depth++;
            end
            smc_pkg::OP_LOAD: begin
               send(op, 32'($urandom_range(0, 2047)));
               depth++;
            end
            smc_pkg::OP_SAVE: if (depth > 0) begin
               send(op, 32'($urandom_range(0, 2047)));
               depth--;
            end
            smc_pkg::OP_ADD, smc_pkg::OP_SUB, smc_pkg::OP_MUL, smc_pkg::OP_EQ,
            smc_pkg::OP_GE, smc_pkg::OP_LE, smc_pkg::OP_NE, smc_pkg::OP_LT,
            smc_pkg::OP_GT:
               if (depth > 1) begin send(op, $urandom); depth--; end
            smc_pkg::OP_MOD: if (depth > 1) begin
               send(smc_pkg::OP_PUSH,
                    $urandom_range(0, 1) ? $urandom : 32'($urandom_range(1, 9)));
               send(smc_pkg::OP_MOD, 0);
               depth--;
            end
            smc_pkg::OP_DUP: if (depth > 0 && depth < 200) begin
               send(op, 0);
               depth++;
            end
            smc_pkg::OP_POP, smc_pkg::OP_SWAP: if (depth > 1) send(op, 0);
            smc_pkg::OP_JMP: send(op, 32'($urandom_range(0, 4095)));
            smc_pkg::OP_JZ: if (depth > 0) begin
               send(op, 32'($urandom_range(0, 4095)));
               depth--;
            end
            smc_pkg::OP_SHOW_STR: begin
               send(smc_pkg::OP_PUSH, 32'($urandom_range(0, 2047)));
               send(smc_pkg::OP_SHOW_STR, 0);
            end
            smc_pkg::OP_HALT: ;                    // saved for the end
            default: send(op, $urandom);
         endcase
      end
      // Error halt on a bad address, then steps while halted.
      send(smc_pkg::OP_LOAD, 32'h8000_0000);
      send(smc_pkg::OP_PUSH, 1);
      send(smc_pkg::OP_HALT, 0);
      req_tvalid <= 0;

      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/smc_pkg.sv
src/smc_datapath.sv
src/smc_controller.sv
src/stack_machine_core.sv
tb/sv/smc_checker.sv
tb/sv/tb_top.sv
